/* rtl/assert_macros.svh */
// Assertion macros used by the complex arithmetic unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CAU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CAU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// Package with the shared types and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   // Default operand width and fraction bits (Q15.16).
   localparam int CAU_DATA_WIDTH = 32;
   localparam int CAU_FRAC_BITS  = 16;
   localparam int CAU_ACT_WIDTH  = 3;

   // Operation codes of a request.
   typedef enum logic [CAU_ACT_WIDTH-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_CMP = 3'd4
   } cau_action_type;

   // Control flags that travel with a request down the pipeline.
   typedef struct packed {
      logic vld;
      logic is_div;
      logic eq;
      logic dz;
      logic neg_re;
      logic neg_im;
      logic big_re;
      logic big_im;
   } cau_flags_type;

endpackage

`default_nettype wire

/* rtl/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit: front end, divider chain and output register.
// Throughput: one request per cycle; the pipeline advances whenever the output
// register is empty or its result is being taken.
// The divider chain has one cell per quotient bit, DATA_WIDTH cells in all.
// Reset is synchronous and active high; it clears all valid flags, no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cau_pkg::CAU_ACT_WIDTH-1:0] req_action,
   input  wire logic signed [DATA_WIDTH-1:0]  req_a_real,
   input  wire logic signed [DATA_WIDTH-1:0]  req_a_imag,
   input  wire logic signed [DATA_WIDTH-1:0]  req_b_real,
   input  wire logic signed [DATA_WIDTH-1:0]  req_b_imag,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]       rsp_res_real,
   output logic signed [DATA_WIDTH-1:0]       rsp_res_imag,
   output logic                               rsp_equal,
   output logic                               rsp_div_zero,
   output logic                               rsp_overflow
);

   localparam int DW = DATA_WIDTH;
   localparam int NW = 2 * DW + 1 + FRAC_BITS;

   logic adv;
   logic rsp_valid_ff;

   // The whole pipeline moves together unless a finished result is held.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   cau_pkg::cau_flags_type c_flags  [DW+1];
   logic [NW-1:0]          c_rem_re [DW+1];
   logic [NW-1:0]          c_rem_im [DW+1];
   logic [DW-1:0]          c_quo_re [DW+1];
   logic [DW-1:0]          c_quo_im [DW+1];
   logic [2*DW-1:0]        c_den    [DW+1];

   cau_front #(.DW(DW), .F(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .action   (req_action),
      .a_real   (req_a_real),
      .a_imag   (req_a_imag),
      .b_real   (req_b_real),
      .b_imag   (req_b_imag),
      .flags    (c_flags[0]),
      .rem_re   (c_rem_re[0]),
      .rem_im   (c_rem_im[0]),
      .den      (c_den[0])
   );

   assign c_quo_re[0] = '0;
   assign c_quo_im[0] = '0;

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < DW; k++) begin : g_cell
      cau_div_cell #(.DW(DW), .F(FRAC_BITS), .BIT(DW - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .flags_i  (c_flags[k]),
         .rem_re_i (c_rem_re[k]),
         .rem_im_i (c_rem_im[k]),
         .quo_re_i (c_quo_re[k]),
         .quo_im_i (c_quo_im[k]),
         .den_i    (c_den[k]),
         .flags_o  (c_flags[k+1]),
         .rem_re_o (c_rem_re[k+1]),
         .rem_im_o (c_rem_im[k+1]),
         .quo_re_o (c_quo_re[k+1]),
         .quo_im_o (c_quo_im[k+1]),
         .den_o    (c_den[k+1])
      );
   end

   // Divide results with a nonzero divisor come from the quotient, all others from the carried magnitude.
   cau_pkg::cau_flags_type fin;
   logic [NW-1:0]          val_re, val_im;
   logic signed [DW-1:0]   sat_re, sat_im;
   logic                   ovf_re, ovf_im;

   assign fin    = c_flags[DW];
   assign val_re = fin.is_div ? NW'(c_quo_re[DW]) : c_rem_re[DW];
   assign val_im = fin.is_div ? NW'(c_quo_im[DW]) : c_rem_im[DW];

   cau_saturate #(.DW(DW), .F(FRAC_BITS)) u_sat_re (
      .neg (fin.neg_re),
      .big (fin.big_re),
      .mag (val_re),
      .res (sat_re),
      .ovf (ovf_re)
   );

   cau_saturate #(.DW(DW), .F(FRAC_BITS)) u_sat_im (
      .neg (fin.neg_im),
      .big (fin.big_im),
      .mag (val_im),
      .res (sat_im),
      .ovf (ovf_im)
   );

   // Output register.
   logic signed [DW-1:0] res_real_ff, res_imag_ff;
   logic                 equal_ff, div_zero_ff, overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_real_ff <= sat_re;
         res_imag_ff <= sat_im;
         equal_ff    <= fin.eq;
         div_zero_ff <= fin.dz;
         overflow_ff <= ovf_re || ovf_im;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = res_real_ff;
   assign rsp_res_imag = res_imag_ff;
   assign rsp_equal    = equal_ff;
   assign rsp_div_zero = div_zero_ff;
   assign rsp_overflow = overflow_ff;

   // Result checks used by the assertions below.
   logic rsp_zero, rsp_at_limit;

   assign rsp_zero     = (rsp_res_real == '0) && (rsp_res_imag == '0);
   assign rsp_at_limit = (rsp_res_real == $signed(~(DW'(1) << (DW - 1))))
                      || (rsp_res_real == $signed(DW'(1) << (DW - 1)))
                      || (rsp_res_imag == $signed(~(DW'(1) << (DW - 1))))
                      || (rsp_res_imag == $signed(DW'(1) << (DW - 1)));

   // A zero divisor gives a zero result without overflow.
   `CAU_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid && rsp_div_zero, rsp_zero && !rsp_overflow, "div_zero result not clean")
   // Compare results carry no other flag.
   `CAU_ASSERT_IMP(a_eq_alone, clock, reset, rsp_valid && rsp_equal, !rsp_div_zero && !rsp_overflow && rsp_zero, "equal with other flags")
   // An overflow leaves at least one part at a range limit.
   `CAU_ASSERT_IMP(a_ovf_limit, clock, reset, rsp_valid && rsp_overflow, rsp_at_limit, "overflow without saturated part")

endmodule

`default_nettype wire

/* rtl/cau_front.sv */
// Front end: products, sums and magnitude preparation ahead of the divider chain.
`timescale 1ns / 1ps
`default_nettype none

module cau_front #(
   parameter int DW = cau_pkg::CAU_DATA_WIDTH,
   parameter int F  = cau_pkg::CAU_FRAC_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_valid,
   input  wire logic [cau_pkg::CAU_ACT_WIDTH-1:0] action,
   input  wire logic signed [DW-1:0]    a_real,
   input  wire logic signed [DW-1:0]    a_imag,
   input  wire logic signed [DW-1:0]    b_real,
   input  wire logic signed [DW-1:0]    b_imag,
   output cau_pkg::cau_flags_type       flags,
   output logic [2*DW+1+F-1:0]          rem_re,
   output logic [2*DW+1+F-1:0]          rem_im,
   output logic [2*DW-1:0]              den
);

   localparam int PW = 2 * DW;
   localparam int SW = 2 * DW + 1;
   localparam int NW = SW + F;
   localparam int CW = (NW > 3 * DW) ? NW : 3 * DW;

   // Stage 1: all products, the linear sums and the compares.
   logic                     s1_vld_ff;
   cau_pkg::cau_action_type  s1_op_ff;
   logic signed [PW-1:0]     s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_bb_ff, s1_qq_ff;
   logic signed [DW:0]       s1_lin_re_ff, s1_lin_im_ff;
   logic                     s1_eq_ff, s1_dz_ff;
   logic signed [DW:0]       lin_re_in, lin_im_in;

   always_comb begin
      if (cau_pkg::cau_action_type'(action) == cau_pkg::ACT_SUB) begin
         lin_re_in = (DW+1)'(a_real) - (DW+1)'(b_real);
         lin_im_in = (DW+1)'(a_imag) - (DW+1)'(b_imag);
      end else begin
         lin_re_in = (DW+1)'(a_real) + (DW+1)'(b_real);
         lin_im_in = (DW+1)'(a_imag) + (DW+1)'(b_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff     <= cau_pkg::cau_action_type'(action);
         s1_rr_ff     <= a_real * b_real;
         s1_ii_ff     <= a_imag * b_imag;
         s1_ri_ff     <= a_real * b_imag;
         s1_ir_ff     <= a_imag * b_real;
         s1_bb_ff     <= b_real * b_real;
         s1_qq_ff     <= b_imag * b_imag;
         s1_lin_re_ff <= lin_re_in;
         s1_lin_im_ff <= lin_im_in;
         s1_eq_ff     <= (a_real == b_real) && (a_imag == b_imag);
         s1_dz_ff     <= (b_real == '0) && (b_imag == '0);
      end
   end

   // Stage 2: form the full-width real and imaginary sums for the operation, and the divisor.
   logic                     s2_vld_ff;
   cau_pkg::cau_action_type  s2_op_ff;
   logic signed [SW-1:0]     s2_re_ff, s2_im_ff;
   logic [PW-1:0]            s2_den_ff;
   logic                     s2_eq_ff, s2_dz_ff;
   logic signed [SW-1:0]     sum_re_in, sum_im_in;

   always_comb begin
      unique case (s1_op_ff)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
            sum_re_in = SW'(s1_lin_re_ff);
            sum_im_in = SW'(s1_lin_im_ff);
         end
         cau_pkg::ACT_MUL: begin
            sum_re_in = SW'(s1_rr_ff) - SW'(s1_ii_ff);
            sum_im_in = SW'(s1_ri_ff) + SW'(s1_ir_ff);
         end
         cau_pkg::ACT_DIV: begin
            sum_re_in = SW'(s1_rr_ff) + SW'(s1_ii_ff);
            sum_im_in = SW'(s1_ir_ff) - SW'(s1_ri_ff);
         end
         default: begin
            sum_re_in = '0;
            sum_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff  <= s1_op_ff;
         s2_re_ff  <= sum_re_in;
         s2_im_ff  <= sum_im_in;
         s2_den_ff <= $unsigned(s1_bb_ff) + $unsigned(s1_qq_ff);
         s2_eq_ff  <= s1_eq_ff;
         s2_dz_ff  <= s1_dz_ff;
      end
   end

   // Stage 3: sign and magnitude, fraction scaling and the quotient range check.
   logic          neg_re, neg_im;
   logic [SW-1:0] mag_re, mag_im;
   logic [NW-1:0] rem_re_in, rem_im_in;
   logic [CW-1:0] den_top;
   cau_pkg::cau_flags_type flags_in;

   always_comb begin
      neg_re  = s2_re_ff < 0;
      neg_im  = s2_im_ff < 0;
      mag_re  = neg_re ? $unsigned(-s2_re_ff) : $unsigned(s2_re_ff);
      mag_im  = neg_im ? $unsigned(-s2_im_ff) : $unsigned(s2_im_ff);
      den_top = CW'(s2_den_ff) << DW;

      flags_in        = '0;
      flags_in.vld    = s2_vld_ff;
      flags_in.neg_re = neg_re;
      flags_in.neg_im = neg_im;
      rem_re_in       = NW'(mag_re);
      rem_im_in       = NW'(mag_im);

      unique case (s2_op_ff)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
         end
         cau_pkg::ACT_MUL: begin
            rem_re_in = NW'(mag_re) >> F;
            rem_im_in = NW'(mag_im) >> F;
         end
         cau_pkg::ACT_DIV: begin
            if (s2_dz_ff) begin
               // A zero divisor returns zero with only the flag set.
               rem_re_in       = '0;
               rem_im_in       = '0;
               flags_in.neg_re = 1'b0;
               flags_in.neg_im = 1'b0;
               flags_in.dz     = 1'b1;
            end else begin
               rem_re_in       = NW'(mag_re) << F;
               rem_im_in       = NW'(mag_im) << F;
               flags_in.is_div = 1'b1;
               flags_in.big_re = CW'(rem_re_in) >= den_top;
               flags_in.big_im = CW'(rem_im_in) >= den_top;
            end
         end
         cau_pkg::ACT_CMP: begin
            rem_re_in       = '0;
            rem_im_in       = '0;
            flags_in.neg_re = 1'b0;
            flags_in.neg_im = 1'b0;
            flags_in.eq     = s2_eq_ff;
         end
         default: begin
            rem_re_in       = '0;
            rem_im_in       = '0;
            flags_in.neg_re = 1'b0;
            flags_in.neg_im = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags <= '0;
      end else if (adv) begin
         flags <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_re <= rem_re_in;
         rem_im <= rem_im_in;
         den    <= s2_den_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/cau_div_cell.sv */
// One cell of the divider chain: decides one quotient bit for both parts.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_cell #(
   parameter int DW  = cau_pkg::CAU_DATA_WIDTH,
   parameter int F   = cau_pkg::CAU_FRAC_BITS,
   parameter int BIT = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire cau_pkg::cau_flags_type flags_i,
   input  wire logic [2*DW+1+F-1:0]    rem_re_i,
   input  wire logic [2*DW+1+F-1:0]    rem_im_i,
   input  wire logic [DW-1:0]          quo_re_i,
   input  wire logic [DW-1:0]          quo_im_i,
   input  wire logic [2*DW-1:0]        den_i,
   output cau_pkg::cau_flags_type      flags_o,
   output logic [2*DW+1+F-1:0]         rem_re_o,
   output logic [2*DW+1+F-1:0]         rem_im_o,
   output logic [DW-1:0]               quo_re_o,
   output logic [DW-1:0]               quo_im_o,
   output logic [2*DW-1:0]             den_o
);

   localparam int NW = 2 * DW + 1 + F;
   localparam int CW = (NW > 3 * DW) ? NW : 3 * DW;

   logic [CW-1:0] step;
   logic [NW-1:0] rem_re_in, rem_im_in;
   logic [DW-1:0] quo_re_in, quo_im_in;

   // Restoring step: subtract the shifted divisor where it fits.
   always_comb begin
      step      = CW'(den_i) << BIT;
      rem_re_in = rem_re_i;
      rem_im_in = rem_im_i;
      quo_re_in = quo_re_i;
      quo_im_in = quo_im_i;
      if (flags_i.is_div && (CW'(rem_re_i) >= step)) begin
         rem_re_in      = rem_re_i - NW'(step);
         quo_re_in[BIT] = 1'b1;
      end
      if (flags_i.is_div && (CW'(rem_im_i) >= step)) begin
         rem_im_in      = rem_im_i - NW'(step);
         quo_im_in[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_o <= '0;
      end else if (adv) begin
         flags_o <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_re_o <= rem_re_in;
         rem_im_o <= rem_im_in;
         quo_re_o <= quo_re_in;
         quo_im_o <= quo_im_in;
         den_o    <= den_i;
      end
   end

endmodule

`default_nettype wire

/* rtl/cau_saturate.sv */
// Sign-magnitude to two's complement conversion with saturation for one part.
`timescale 1ns / 1ps
`default_nettype none

module cau_saturate #(
   parameter int DW = cau_pkg::CAU_DATA_WIDTH,
   parameter int F  = cau_pkg::CAU_FRAC_BITS
) (
   input  wire logic                 neg,
   input  wire logic                 big,
   input  wire logic [2*DW+1+F-1:0]  mag,
   output logic signed [DW-1:0]      res,
   output logic                      ovf
);

   localparam int NW = 2 * DW + 1 + F;

   logic [NW-1:0] lim;
   logic [DW-1:0] max_val, min_val;

   // Positive limit is one below the magnitude of the negative limit.
   always_comb begin
      lim     = NW'(1) << (DW - 1);
      min_val = DW'(1) << (DW - 1);
      max_val = ~min_val;
      ovf     = 1'b0;
      if (big || (!neg && (mag >= lim)) || (neg && (mag > lim))) begin
         ovf = 1'b1;
         res = neg ? $signed(min_val) : $signed(max_val);
      end else if (neg) begin
         res = $signed(-mag[DW-1:0]);
      end else begin
         res = $signed(mag[DW-1:0]);
      end
   end

endmodule

`default_nettype wire
